/* hdl/psbd_pkg.sv */
package psbd_pkg;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam int DEPTH_DEFAULT = 128;
  localparam logic [7:0] CAPACITY_RESET = 8'd128;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic [7:0]         occupancy;
  } result_t;

endpackage

/* hdl/parity_steered_bounded_deque_unit.sv */
// Bounded deque of signed 32-bit values in a DEPTH-entry ring memory. An item is
// taken on any cycle with start high; busy stays low, so one item per cycle is
// sustained. Each item gives exactly one result on response, marked by done in the
// cycle after the transfer, in step with the registered read of the ring memory,
// which a pop needs for its front entry. The receiver cannot stall, so results
// must be taken as they appear. Inserts of even values go to the back, odd
// values to the front; capacity (APB register at address 0) caps the count,
// saturating at DEPTH. The ring memory is not cleared at reset and needs no
// clearing pass.
module parity_steered_bounded_deque_unit #(
  parameter int DEPTH = psbd_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  psbd_pkg::item_t   request,
  output logic              done,
  output psbd_pkg::result_t response,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import psbd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 8) ? CW : 8;
  localparam int SW = AW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  // ring memory
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;

  // control registers
  logic [7:0]    capacity;
  logic [AW-1:0] front;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // result stage
  logic       pop_ok;
  logic [1:0] status;
  logic [7:0] occupancy;

  logic          accept;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    status_next;
  logic [SW-1:0] back_sum;
  logic [AW-1:0] back_slot;
  logic [AW-1:0] front_prev;
  logic [AW-1:0] front_succ;
  logic [LW-1:0] limit;
  logic [LW-1:0] cap_l;
  logic          is_full;
  logic          is_empty;
  logic          cfg_write;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // apb register access
  assign cfg_write = psel && penable && pwrite && pready && (paddr == 2'd0);
  assign prdata    = (paddr == 2'd0) ? {24'd0, capacity} : 32'd0;

  // ring position arithmetic
  assign back_sum   = SW'(front) + SW'(count);
  assign back_slot  = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
  assign front_prev = (front == '0) ? LAST_SLOT : front - AW'(1);
  assign front_succ = (front == LAST_SLOT) ? '0 : front + AW'(1);

  // limit saturates at the ring size
  assign cap_l    = LW'(capacity);
  assign limit    = (cap_l > DEPTH_L) ? DEPTH_L : cap_l;
  assign is_full  = LW'(count) >= limit;
  assign is_empty = (count == '0);

  // next state of the deque for one item
  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = ST_OK;
    wr_en       = 1'b0;
    wr_addr     = back_slot;
    if (request.operation == OP_INSERT) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else if (!request.value[0]) begin
        wr_en      = 1'b1;
        count_next = count + CW'(1);
      end else begin
        wr_en      = 1'b1;
        wr_addr    = front_prev;
        front_next = front_prev;
        count_next = count + CW'(1);
      end
    end else begin
      if (is_empty) begin
        status_next = ST_EMPTY;
      end else begin
        front_next = front_succ;
        count_next = count - CW'(1);
      end
    end
  end

  // memory write and registered read of the front entry
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= request.value;
    end
    rdata <= mem[front];
  end

  // control state and result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      front    <= '0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= pwdata[7:0];
      end
      done <= accept;
      if (accept) begin
        front <= front_next;
        count <= count_next;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      pop_ok    <= (request.operation == OP_POP) && !is_empty;
      occupancy <= 8'(count_next);
    end
  end

  always_comb begin
    response.status       = status;
    response.popped_value = pop_ok ? rdata : 32'd0;
    response.occupancy    = occupancy;
  end

  // checks
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done) else $error("transfer without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept)) else $error("result without transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(count) <= CW'(DEPTH)) else $error("count above ring size");

  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (done && response.status == ST_FULL) |-> response.occupancy == $past(8'(count)))
    else $error("rejected insert changed count");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && request.operation == OP_POP && !is_empty) |=> count == $past(count) - CW'(1))
    else $error("pop did not shrink count");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import psbd_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  // tracks deque contents and the results each accepted item should produce
  class deque_tracker;
    logic [31:0] ring [DEPTH];
    int          front;
    int          count;
    logic [7:0]  capacity;
    result_t     awaited [$];
    int          errors;

    function new();
      front    = 0;
      count    = 0;
      capacity = CAPACITY_RESET;
      errors   = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function void set_capacity(logic [31:0] data);
      capacity = data[7:0];
    endfunction

    // apply one accepted item to the mirror and queue its result
    function void note_item(item_t it);
      result_t r;
      int      lim;
      r.status       = ST_OK;
      r.popped_value = '0;
      lim = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
      if (it.operation == OP_INSERT) begin
        if (count >= lim) begin
          r.status = ST_FULL;
        end else if (!it.value[0]) begin
          ring[(front + count) % DEPTH] = it.value;
          count++;
        end else begin
          front = (front == 0) ? DEPTH - 1 : front - 1;
          ring[front] = it.value;
          count++;
        end
      end else if (count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped_value = ring[front];
        front = (front + 1) % DEPTH;
        count--;
      end
      r.occupancy = count[7:0];
      awaited = {awaited, r};
    endfunction

    // compare one result transfer against the oldest expectation
    function void check_result(result_t got);
      result_t exp;
      if (awaited.size() == 0) begin
        $error("result with nothing expected: status %0d popped %0d occupancy %0d",
               got.status, got.popped_value, got.occupancy);
        errors++;
        return;
      end
      exp = awaited[0];
      awaited.delete(0);
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.popped_value !== exp.popped_value) begin
        $error("popped_value: expected %0d, got %0d", exp.popped_value, got.popped_value);
        errors++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  item_t       request;
  logic        done;
  result_t     response;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  deque_tracker tracker = new();

  parity_steered_bounded_deque_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // item and result transfers, sampled at the edge that completes them
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.note_item(request);
      if (done) tracker.check_result(response);
    end
  end

  // present one item and hold it until the transfer
  task automatic send_item(item_t it);
    start   <= 1'b1;
    request <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_insert(logic [31:0] v);
    item_t it;
    it.operation = OP_INSERT;
    it.value     = v;
    send_item(it);
  endtask

  // value is don't-care on a pop, so keep it random
  task automatic send_pop();
    item_t it;
    it.operation = OP_POP;
    it.value     = $urandom;
    send_item(it);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  // capacity write through the apb port, only with the deque idle
  task automatic write_capacity(logic [31:0] data);
    drain();
    repeat (3) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_capacity(data);
  endtask

  // bursts with a varying insert share so the deque swings between full and empty
  task automatic run_traffic(int n_items, int idle_pct);
    int          left;
    int          burst;
    int          ins_pct;
    logic [31:0] v;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(150, 10);
      case ($urandom_range(2))
        0:       ins_pct = 10;
        1:       ins_pct = 50;
        default: ins_pct = 90;
      endcase
      for (int k = 0; k < burst && left > 0; k++) begin
        if ($urandom_range(99) == 0) begin
          drain();
        end else begin
          while ($urandom_range(99) < idle_pct) idle_cycle();
        end
        if ($urandom_range(99) < ins_pct) begin
          case ($urandom_range(9))
            0:       v = 32'h0000_0000;
            1:       v = 32'hFFFF_FFFF;
            2:       v = 32'h7FFF_FFFF;
            3:       v = 32'h8000_0000;
            default: v = $urandom;
          endcase
          send_insert(v);
        end else begin
          send_pop();
        end
        left--;
      end
    end
  endtask

  // stimulus
  initial begin
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes and parity steering at reset capacity, pop on empty
    send_pop();
    send_insert(32'h0000_0000);
    send_insert(32'hFFFF_FFFF);
    send_insert(32'h7FFF_FFFF);
    send_insert(32'h8000_0000);
    repeat (5) send_pop();

    // zero capacity rejects every insert
    write_capacity(32'hFFFF_FF00);
    send_insert(32'h0000_0004);
    send_pop();

    // capacity above depth saturates
    write_capacity(32'h0000_00FF);
    send_insert(32'h0000_0006);
    send_insert(32'h0000_0007);
    send_insert(32'hFFFF_FFF8);
    send_insert(32'h8000_0001);

    // capacity lowered below occupancy keeps held entries
    write_capacity(32'd2);
    send_insert(32'h0000_000A);
    repeat (3) send_pop();
    send_insert(32'h0000_000B);
    send_insert(32'h0000_000C);
    repeat (2) send_pop();

    // random phases over several capacities and sender idle rates
    write_capacity(32'h0000_00FF);
    run_traffic(120, 0);
    write_capacity(32'd1);
    run_traffic(120, 49);
    write_capacity({24'($urandom_range(255, 0)), 8'd128});
    run_traffic(120, 0);
    write_capacity(32'd7);
    run_traffic(120, 17);
    write_capacity($urandom_range(127, 2));
    run_traffic(120, 49);
    write_capacity(32'd64);
    run_traffic(120, 0);

    drain();
    repeat (5) @(posedge clk);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
